[rtl/smd_pkg.sv]
// ----------------------------------------------------------------------------
// smd_pkg: shared types and constants of the sensor message deframer
// Byte positions of the header, length overheads, status and item class
// codes, and the record passed from the front end to the output stage.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned IDX_W       = 9;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam int unsigned DEF_MAX_MESSAGE_BYTES = 256;

    // front/back queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_ID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_MARK = 2'd2;

    localparam logic [BYTE_W-1:0] RST_PREAMBLE = 8'd250;
    localparam logic [BYTE_W-1:0] RST_BUS_ID   = 8'd255;
    localparam logic [BYTE_W-1:0] RST_EXT_MARK = 8'd255;

    // header positions
    localparam int unsigned POS_BUS_ID = 1;
    localparam int unsigned POS_LENGTH = 3;
    localparam int unsigned POS_EXT_HI = 4;
    localparam int unsigned POS_EXT_LO = 5;
    localparam int unsigned POS_LEN_KNOWN = 3;  // end check only past this count

    localparam int unsigned NORMAL_OVERHEAD   = 5;
    localparam int unsigned EXTENDED_OVERHEAD = 7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

    // item class decided by the front end
    localparam logic [1:0] CLS_MID = 2'd0;
    localparam logic [1:0] CLS_END = 2'd1;
    localparam logic [1:0] CLS_ERR = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] prm;
        logic [BYTE_W-1:0] bus_id;
        logic [BYTE_W-1:0] ext_mark;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [1:0]        cls;
        logic              hdr_ok;
        logic              sum_zero;
    } t_rec;

endpackage

[rtl/smd_byte_if.sv]
// ----------------------------------------------------------------------------
// smd_byte_if: received byte channel
// Valid/ready channel carrying one serial byte per item.
// ----------------------------------------------------------------------------
interface smd_byte_if
    import smd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/smd_msg_if.sv]
// ----------------------------------------------------------------------------
// smd_msg_if: message byte channel
// Valid/ready channel carrying one message byte with index and status.
// ----------------------------------------------------------------------------
interface smd_msg_if
    import smd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   data_byte;
    logic [IDX_W-1:0]    byte_index;
    logic                is_last;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output data_byte, output byte_index,
                    output is_last, output status, input ready);
    modport sink   (input valid, input data_byte, input byte_index,
                    input is_last, input status, output ready);
endinterface

[rtl/smd_front.sv]
// ----------------------------------------------------------------------------
// smd_front: preamble hunt and message state tracking
// Filters bytes while hunting, tracks index, length, sum and header check,
// and classifies each message byte into a record for the queue.
// ----------------------------------------------------------------------------
module smd_front
    import smd_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    smd_byte_if.sink    i_rx,
    input  logic        i_full,
    output logic        o_push,
    output t_rec        o_rec
);

    localparam int unsigned CW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int unsigned LW = 18;
    localparam logic [CW-1:0]  MAX_C = CW'(MAX_MESSAGE_BYTES);
    localparam logic [LW-1:0]  MAX_L = LW'(MAX_MESSAGE_BYTES);

    logic              r_in_msg, n_in_msg;
    logic [CW-1:0]     r_count,  n_count;
    logic [LEN_W-1:0]  r_decl,   n_decl;
    logic [BYTE_W-1:0] r_sum,    n_sum;
    logic              r_ext,    n_ext;
    logic              r_hdr_ok, n_hdr_ok;

    logic              take;
    logic              active;
    logic              too_large;
    logic              done;
    logic [CW-1:0]     cnt_inc;
    logic [LEN_W-1:0]  decl_upd;
    logic [BYTE_W-1:0] sum_upd;
    logic              ext_upd;
    logic              hdr_upd;
    logic [LW-1:0]     end_len;
    logic [BYTE_W-1:0] b;

    assign b        = i_rx.rx_byte;
    assign i_rx.ready = !i_full;
    assign take     = i_rx.valid && !i_full;
    // while hunting all state already sits at its start values
    assign active   = r_in_msg || (b == i_cfg.prm);

    always_comb begin
        too_large = (LW'(r_decl) > MAX_L) || (r_count >= MAX_C);

        hdr_upd = (r_count == CW'(POS_BUS_ID)) ? (b == i_cfg.bus_id) : r_hdr_ok;
        ext_upd = r_ext || ((r_count == CW'(POS_LENGTH)) && (b == i_cfg.ext_mark));

        decl_upd = r_decl;
        if ((r_count == CW'(POS_LENGTH)) && (b != i_cfg.ext_mark)) begin
            decl_upd = LEN_W'(b);
        end else if (r_ext && (r_count == CW'(POS_EXT_HI))) begin
            decl_upd = {b, 8'h00};
        end else if (r_ext && (r_count == CW'(POS_EXT_LO))) begin
            decl_upd = {r_decl[LEN_W-1:BYTE_W], b};
        end

        sum_upd = (r_count != '0) ? (r_sum + b) : r_sum;
        cnt_inc = r_count + 1'b1;

        end_len = LW'(decl_upd) + (ext_upd ? LW'(EXTENDED_OVERHEAD) : LW'(NORMAL_OVERHEAD));
        done    = (cnt_inc > CW'(POS_LEN_KNOWN)) && (LW'(cnt_inc) == end_len);
    end

    always_comb begin
        o_rec.data_byte  = b;
        o_rec.byte_index = IDX_W'(r_count);
        o_rec.hdr_ok     = hdr_upd;
        o_rec.sum_zero   = (sum_upd == '0);
        if (too_large) begin
            o_rec.cls = CLS_ERR;
        end else if (done) begin
            o_rec.cls = CLS_END;
        end else begin
            o_rec.cls = CLS_MID;
        end
    end

    assign o_push = take && active;

    always_comb begin
        n_in_msg = r_in_msg;
        n_count  = r_count;
        n_decl   = r_decl;
        n_sum    = r_sum;
        n_ext    = r_ext;
        n_hdr_ok = r_hdr_ok;
        if (o_push) begin
            if (too_large || done) begin
                n_in_msg = 1'b0;
                n_count  = '0;
                n_decl   = '0;
                n_sum    = '0;
                n_ext    = 1'b0;
                n_hdr_ok = 1'b1;
            end else begin
                n_in_msg = 1'b1;
                n_count  = cnt_inc;
                n_decl   = decl_upd;
                n_sum    = sum_upd;
                n_ext    = ext_upd;
                n_hdr_ok = hdr_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_count  <= '0;
            r_decl   <= '0;
            r_sum    <= '0;
            r_ext    <= 1'b0;
            r_hdr_ok <= 1'b1;
        end else begin
            r_in_msg <= n_in_msg;
            r_count  <= n_count;
            r_decl   <= n_decl;
            r_sum    <= n_sum;
            r_ext    <= n_ext;
            r_hdr_ok <= n_hdr_ok;
        end
    end

`ifndef SYNTHESIS
    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_msg |-> (r_count == '0 && r_sum == '0 && r_decl == '0 && !r_ext))
        else $error("front: state not cleared while hunting");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("front: push into full queue");
    a_start_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !r_in_msg) |-> (o_rec.byte_index == '0 && o_rec.cls == CLS_MID))
        else $error("front: message does not start at index zero");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_C)
        else $error("front: byte count past capacity");
`endif

endmodule

[rtl/smd_queue.sv]
// ----------------------------------------------------------------------------
// smd_queue: short record queue between front end and output stage
// Register-based FIFO; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module smd_queue
    import smd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_rec o_rec
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? QPTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = i_pop  ? QPTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue: pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue: fill count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != (QPTR_W+1)'(QUEUE_DEPTH)) |-> (r_wr != r_rd))
        else $error("queue: pointers disagree with fill count");
`endif

endmodule

[rtl/smd_back.sv]
// ----------------------------------------------------------------------------
// smd_back: status resolution and output register
// Turns a queued record into index, last flag and status, held in an
// output register until taken.
// ----------------------------------------------------------------------------
module smd_back
    import smd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_rec        i_rec,
    output logic        o_pop,
    smd_msg_if.source   o_msg
);

    logic                r_valid, n_valid;
    logic [BYTE_W-1:0]   r_data;
    logic [IDX_W-1:0]    r_idx;
    logic                r_last;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] status_c;

    assign o_pop = !i_empty && (!r_valid || o_msg.ready);

    // priority: too large, then header, then checksum
    always_comb begin
        priority if (i_rec.cls == CLS_ERR) begin
            status_c = ST_TOO_LARGE;
        end else if (i_rec.cls == CLS_END && !i_rec.hdr_ok) begin
            status_c = ST_BAD_HDR;
        end else if (i_rec.cls == CLS_END && !i_rec.sum_zero) begin
            status_c = ST_CHECKSUM;
        end else begin
            status_c = ST_OK;
        end
    end

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_msg.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= i_rec.data_byte;
            r_idx    <= i_rec.byte_index;
            r_last   <= (i_rec.cls != CLS_MID);
            r_status <= status_c;
        end
    end

    assign o_msg.valid      = r_valid;
    assign o_msg.data_byte  = r_data;
    assign o_msg.byte_index = r_idx;
    assign o_msg.is_last    = r_last;
    assign o_msg.status     = r_status;

endmodule

[rtl/sensor_message_deframer.sv]
// ----------------------------------------------------------------------------
// sensor_message_deframer: preamble / length / checksum message receiver
// Path: an accepted byte is written into the queue, then loaded into the
// output register and offered at the output from there.
// Throughput: one byte per cycle while the queue is not full.
// Reset (synchronous, active low): hunting, queue empty, output invalid,
// registers back to preamble 250, bus id 255, extended marker 255.
// ----------------------------------------------------------------------------
module sensor_message_deframer
    import smd_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    smd_byte_if.sink             i_rx,
    smd_msg_if.source            o_msg
);

    // Structure:
    //   front  - hunts for the preamble, keeps index / length / sum / header
    //            state, and tags each message byte as mid, end or too large.
    //            Bytes seen while hunting are taken and dropped.
    //   queue  - four-entry FIFO; front ready is simply "queue not full",
    //            so an output stall never reaches the input combinationally.
    //   back   - works out the status of an end item and holds the item in
    //            the output register until it is taken.

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_rec rec_in;
    t_rec rec_out;

    // Configuration registers; writes to an unused index are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PREAMBLE: n_cfg.prm      = i_cfg_wdata;
                CFG_BUS_ID:   n_cfg.bus_id   = i_cfg_wdata;
                CFG_EXT_MARK: n_cfg.ext_mark = i_cfg_wdata;
                default:      n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prm      <= RST_PREAMBLE;
            r_cfg.bus_id   <= RST_BUS_ID;
            r_cfg.ext_mark <= RST_EXT_MARK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    smd_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_rx    (i_rx),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_rec   (rec_in)
    );

    smd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (rec_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (rec_out)
    );

    smd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_rec   (rec_out),
        .o_pop   (q_pop),
        .o_msg   (o_msg)
    );

endmodule

[tb/sensor_message_deframer_tb.sv]
// ----------------------------------------------------------------------------
// sensor_message_deframer_tb: self-checking bench for the message deframer
// Feeds byte streams of framed messages, broken frames and line noise under
// several register settings, with random gaps on both channels. A scoreboard
// tracks the framing state per accepted item and checks every message item
// in order.
// ----------------------------------------------------------------------------
module sensor_message_deframer_tb;
    import smd_pkg::*;

    localparam int unsigned MAX_BYTES     = DEF_MAX_MESSAGE_BYTES;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int unsigned SETTLE_CYCLES = 4;     // covers the queue and the output register
    localparam int unsigned PHASE_BYTES   = 130;   // minimum framed bytes per phase
    localparam int unsigned NUM_PHASES    = 5;

    // one item on the message channel
    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic [IDX_W-1:0]    byte_index;
        logic                is_last;
        logic [STATUS_W-1:0] status;
    } t_msg_item;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the framing state and registers; one expected
    // item per accepted byte that is not discarded while hunting.
    // ------------------------------------------------------------------------
    class t_scoreboard;
        logic [BYTE_W-1:0] prm_reg;
        logic [BYTE_W-1:0] bus_reg;
        logic [BYTE_W-1:0] ext_reg;

        bit                in_message;
        int unsigned       byte_count;
        int unsigned       declared_length;
        logic [BYTE_W-1:0] running_sum;
        bit                extended_mode;
        bit                header_ok;

        t_msg_item         expected_msgs[$];
        int                errors;

        function new();
            prm_reg = RST_PREAMBLE;
            bus_reg = RST_BUS_ID;
            ext_reg = RST_EXT_MARK;
            errors  = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            in_message      = 1'b0;
            byte_count      = 0;
            declared_length = 0;
            running_sum     = '0;
            extended_mode   = 1'b0;
            header_ok       = 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_PREAMBLE: prm_reg = val;
                CFG_BUS_ID:   bus_reg = val;
                CFG_EXT_MARK: ext_reg = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_msgs.size();
        endfunction

        // accepted input item
        function void note_byte(logic [BYTE_W-1:0] b);
            int unsigned idx;
            int unsigned overhead;
            t_msg_item   m;
            if (!in_message) begin
                if (b != prm_reg) return;
                restart_hunt();
                in_message = 1'b1;
            end
            idx          = byte_count;
            m.data_byte  = b;
            m.byte_index = IDX_W'(idx);
            // too large: declared length over capacity or index at capacity
            if (declared_length > MAX_BYTES || idx >= MAX_BYTES) begin
                m.is_last = 1'b1;
                m.status  = ST_TOO_LARGE;
                expected_msgs.push_back(m);
                restart_hunt();
                return;
            end
            if (idx == POS_BUS_ID) header_ok = (b == bus_reg);
            if (idx == POS_LENGTH) begin
                if (b == ext_reg) extended_mode = 1'b1;
                else declared_length = b;
            end
            if (extended_mode && idx == POS_EXT_HI) declared_length = {b, 8'h00};
            if (extended_mode && idx == POS_EXT_LO) declared_length = declared_length | b;
            if (idx > 0) running_sum = running_sum + b;
            byte_count = idx + 1;
            overhead   = extended_mode ? EXTENDED_OVERHEAD : NORMAL_OVERHEAD;
            if (byte_count > POS_LEN_KNOWN && byte_count == declared_length + overhead) begin
                m.is_last = 1'b1;
                if (!header_ok) m.status = ST_BAD_HDR;
                else if (running_sum != 0) m.status = ST_CHECKSUM;
                else m.status = ST_OK;
                restart_hunt();
            end else begin
                m.is_last = 1'b0;
                m.status  = ST_OK;
            end
            expected_msgs.push_back(m);
        endfunction

        // accepted output item
        function void check_msg(t_msg_item got);
            t_msg_item want;
            if (expected_msgs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: byte %02h idx %0d last %0b st %0d",
                             got.data_byte, got.byte_index, got.is_last, got.status);
                return;
            end
            want = expected_msgs.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp byte %02h idx %0d last %0b st %0d,",
                             want.data_byte, want.byte_index, want.is_last, want.status,
                             " got byte %02h idx %0d last %0b st %0d",
                             got.data_byte, got.byte_index, got.is_last, got.status);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, block under test
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_wdata;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    smd_byte_if rx_if();
    smd_msg_if  msg_if();

    sensor_message_deframer #(
        .MAX_MESSAGE_BYTES(MAX_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .i_rx       (rx_if),
        .o_msg      (msg_if)
    );

    t_scoreboard sb = new();

    // stimulus state shared by the driving processes
    logic [BYTE_W-1:0] stim_bytes[$];
    logic [BYTE_W-1:0] cur_prm = RST_PREAMBLE;
    logic [BYTE_W-1:0] cur_bus = RST_BUS_ID;
    logic [BYTE_W-1:0] cur_ext = RST_EXT_MARK;
    bit tx_calm;                // sender offers back to back
    bit rx_calm;                // receiver always ready
    int hold_requests = 0;      // bumped to ask for one long hold-off
    int hold_at;                // stream position of the hold-off request
    int pause_at;               // stream position where the sender drains
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready)
                sb.note_byte(rx_if.rx_byte);
            if (msg_if.valid && msg_if.ready)
                sb.check_msg('{msg_if.data_byte, msg_if.byte_index,
                               msg_if.is_last, msg_if.status});
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // gap lengths: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request, counted
    // here so the sender keeps offering meanwhile.
    // ------------------------------------------------------------------------
    initial begin : ready_driver
        int stall_left;
        int holds_done;
        stall_left   = 0;
        holds_done   = 0;
        msg_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !rx_calm && $urandom_range(0, 99) < 30) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                msg_if.ready = 1'b0;
                stall_left--;
            end else begin
                msg_if.ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------
    // Append one message; returns its byte count. A normal length that
    // collides with the marker (or does not fit a byte) goes extended.
    function automatic int add_message(int unsigned len, bit use_ext,
                                       bit bus_good, bit sum_good);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int unsigned       body;
        int                start;
        start = stim_bytes.size();
        if (!use_ext && (len > 255 || len[7:0] == cur_ext)) use_ext = 1'b1;
        stim_bytes.push_back(cur_prm);
        b = bus_good ? cur_bus : cur_bus ^ 8'($urandom_range(1, 255));
        stim_bytes.push_back(b);
        stim_bytes.push_back(8'($urandom_range(0, 255)));   // message id
        if (use_ext) begin
            stim_bytes.push_back(cur_ext);
            stim_bytes.push_back(len[15:8]);
            stim_bytes.push_back(len[7:0]);
        end else begin
            stim_bytes.push_back(len[7:0]);
        end
        // oversize declarations abort at once; past capacity plus four only a short tail follows
        body = (len > MAX_BYTES + 4) ? 3 : len;
        repeat (body) stim_bytes.push_back(8'($urandom_range(0, 255)));
        sum = '0;
        for (int i = start + 1; i < stim_bytes.size(); i++) sum = sum + stim_bytes[i];
        b = -sum;
        if (!sum_good) b = b ^ 8'($urandom_range(1, 255));
        stim_bytes.push_back(b);
        return stim_bytes.size() - start;
    endfunction

    // one random element of the stream; returns framed bytes added
    function automatic int add_random_element();
        int  r;
        bit  bus_good;
        bit  sum_good;
        int  n;
        r        = $urandom_range(0, 99);
        bus_good = $urandom_range(0, 9) != 0;
        sum_good = $urandom_range(0, 6) != 0;
        if (r < 55) return add_message($urandom_range(0, 12), 1'b0, bus_good, sum_good);
        if (r < 70) return add_message($urandom_range(13, 40), 1'b0, bus_good, sum_good);
        if (r < 80) return add_message($urandom_range(0, 20), 1'b1, bus_good, sum_good);
        if (r < 84) begin
            // declared length beyond capacity
            case ($urandom_range(0, 2))
                0:       n = 257;
                1:       n = 65535;
                default: n = $urandom_range(258, 65534);
            endcase
            return add_message(n, 1'b1, bus_good, sum_good);
        end
        if (r < 85) return add_message($urandom_range(240, 251), 1'b0, bus_good, sum_good);
        if (r < 96) begin
            // line noise, ignored while hunting
            repeat ($urandom_range(1, 4)) stim_bytes.push_back(8'($urandom_range(0, 255)));
            return 0;
        end
        // frame cut short before its length byte
        n = $urandom_range(1, 3);
        stim_bytes.push_back(cur_prm);
        if (n > 1) stim_bytes.push_back(cur_bus);
        if (n > 2) stim_bytes.push_back(8'($urandom_range(0, 255)));
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks; each starts and ends at a falling edge
    // ------------------------------------------------------------------------
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, val);
        case (idx)
            CFG_PREAMBLE: cur_prm = val;
            CFG_BUS_ID:   cur_bus = val;
            CFG_EXT_MARK: cur_ext = val;
            default: ;
        endcase
    endtask

    task automatic send_stream();
        int gap;
        foreach (stim_bytes[i]) begin
            if (i == pause_at) begin
                rx_if.valid = 1'b0;
                wait_drained();
            end
            if (i == hold_at) hold_requests++;
            rx_if.valid   = 1'b1;
            rx_if.rx_byte = stim_bytes[i];
            do @(posedge i_clk); while (rx_if.ready !== 1'b1);
            @(negedge i_clk);
            if (!tx_calm && $urandom_range(0, 99) < 30) begin
                gap = gap_len();
                rx_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        rx_if.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int framed;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_PREAMBLE;
        cfg_wdata     = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        tx_calm       = 1'b1;
        rx_calm       = 1'b1;
        hold_at       = -1;
        pause_at      = -1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            stim_bytes.delete();
            hold_at  = -1;
            pause_at = -1;
            framed   = 0;
            if (phase > 0) begin
                // registers only change with nothing in flight
                wait_drained();
                repeat (SETTLE_CYCLES) @(negedge i_clk);
                case (phase)
                    1: begin
                        write_reg(CFG_PREAMBLE, 8'h00);
                        write_reg(CFG_BUS_ID,   8'h00);
                        write_reg(CFG_EXT_MARK, 8'h00);
                    end
                    2: begin
                        write_reg(CFG_PREAMBLE, 8'hFF);
                        write_reg(CFG_BUS_ID,   8'hFF);
                        write_reg(CFG_EXT_MARK, 8'hFF);
                    end
                    default: begin
                        write_reg(CFG_PREAMBLE, 8'($urandom_range(0, 255)));
                        write_reg(CFG_BUS_ID,   8'($urandom_range(0, 255)));
                        write_reg(CFG_EXT_MARK, 8'($urandom_range(0, 255)));
                    end
                endcase
            end

            case (phase)
                0: begin
                    // directed: noise at both extremes, good frame, bad bus id,
                    // bad checksum, extended frame of zero length
                    stim_bytes.push_back(8'h00);
                    stim_bytes.push_back(8'hFF);
                    framed += add_message(0, 1'b0, 1'b1, 1'b1);
                    framed += add_message(0, 1'b0, 1'b0, 1'b1);
                    framed += add_message(0, 1'b0, 1'b1, 1'b0);
                    framed += add_message(0, 1'b1, 1'b1, 1'b1);
                    tx_calm = 1'b1;
                    rx_calm = 1'b1;
                end
                1: begin
                    // normal length 255 runs the index up to capacity; the
                    // long hold-off lands in the middle of that message
                    framed += add_message(255, 1'b0, 1'b1, 1'b1);
                    tx_calm = 1'b1;
                    rx_calm = 1'b0;
                    hold_at = 100;
                end
                2: begin
                    tx_calm = 1'b0;
                    rx_calm = 1'b0;
                end
                3: begin
                    tx_calm = 1'b0;
                    rx_calm = 1'b0;
                end
                default: begin
                    tx_calm = 1'b0;
                    rx_calm = 1'b1;
                end
            endcase
            while (framed < PHASE_BYTES) framed += add_random_element();
            if (phase == 2) pause_at = stim_bytes.size() / 2;
            send_stream();
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/smd_pkg.sv
rtl/smd_byte_if.sv
rtl/smd_msg_if.sv
rtl/smd_front.sv
rtl/smd_queue.sv
rtl/smd_back.sv
rtl/sensor_message_deframer.sv
tb/sensor_message_deframer_tb.sv
